// ----- rtl/gnss_fix_validity_readiness_core_macros.svh -----
`ifndef GNSS_FIX_VALIDITY_READINESS_CORE_MACROS_SVH
`define GNSS_FIX_VALIDITY_READINESS_CORE_MACROS_SVH

// checked only while out of reset
`define GFVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define GFVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/gfvr_pkg.sv -----
package gfvr_pkg;

  localparam int unsigned NOW_W   = 40;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECENT_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HORIZ_ACC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VERT_ACC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_ACC = 3'd4;

  localparam logic [CNT_W-1:0] RST_STABLE_NEEDED = 3'd5;
  localparam logic [LIM_W-1:0] RST_RECENT_WINDOW = 16'd300;
  localparam logic [LIM_W-1:0] RST_MAX_HORIZ_ACC = 16'd10000;
  localparam logic [LIM_W-1:0] RST_MAX_VERT_ACC  = 16'd15000;
  localparam logic [LIM_W-1:0] RST_MAX_SPEED_ACC = 16'd5000;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // fix type codes
  localparam logic [7:0] FIX_3D        = 8'd2;
  localparam logic [7:0] FIX_RTK_FIXED = 8'd5;
  localparam logic [7:0] FIX_MAX_CODE  = 8'd6;

  // time status codes
  localparam logic [7:0] TS_LOCAL_FREE_RUN = 8'd1;
  localparam logic [7:0] TS_GPTP_SYNCED    = 8'd2;
  localparam logic [7:0] TS_GPTP_HOLDOVER  = 8'd3;

  // flag bits
  localparam int unsigned FLAG_TIME_BIT   = 0;
  localparam int unsigned FLAG_COURSE_BIT = 1;
  localparam int unsigned FLAG_YAW_BIT    = 2;
  localparam logic [7:0]  FLAG_ALLOWED    = 8'h0f;

  localparam logic [15:0] ANGLE_LIMIT = 16'd36000;

  localparam logic signed [31:0] LAT_HIGH = 32'sd900000000;
  localparam logic signed [31:0] LAT_LOW  = -32'sd900000000;
  localparam logic signed [31:0] LON_HIGH = 32'sd1800000000;
  localparam logic signed [31:0] LON_LOW  = -32'sd1800000000;
  localparam logic signed [31:0] ALT_HIGH = 32'sd20000000;
  localparam logic signed [31:0] ALT_LOW  = -32'sd1000000;

  // first member sits in the highest bits
  typedef struct packed {
    logic [47:0]      tail_padding;
    logic [47:0]      accuracy_word;
    logic [31:0]      angles_word;
    logic [63:0]      unix_time_ns;
    logic [23:0]      status_word;
    logic [31:0]      altitude_mm;
    logic [31:0]      longitude_e7;
    logic [31:0]      latitude_e7;
    logic [63:0]      capture_time_ns;
    logic             new_session;
    logic [NOW_W-1:0] now_ms;
  } item_t;

  localparam int unsigned ITEM_W   = $bits(item_t);
  localparam int unsigned IN_DATA_W = ((ITEM_W + 7) / 8) * 8;

  typedef struct packed {
    logic [LIM_W-1:0] horiz;
    logic [LIM_W-1:0] vert;
    logic [LIM_W-1:0] speed;
  } acc_lim_t;

  typedef struct packed {
    logic valid;
    logic usable;
  } chk_t;

endpackage

// ----- rtl/gfvr_check.sv -----
module gfvr_check
  import gfvr_pkg::*;
(
  input  item_t    item,
  input  acc_lim_t lim,
  output chk_t     chk
);

  logic [7:0]         fix_code;
  logic [7:0]         flags;
  logic [7:0]         tstat;
  logic [15:0]        course;
  logic [15:0]        yaw;
  logic signed [31:0] lat;
  logic signed [31:0] lon;
  logic signed [31:0] alt;
  logic               tstat_ok;
  logic               time_ok;
  logic               course_ok;
  logic               yaw_ok;
  logic               fix_ok;
  logic               alt_ok;
  logic               acc_ok;

  assign fix_code = item.status_word[7:0];
  assign flags    = item.status_word[15:8];
  assign tstat    = item.status_word[23:16];
  assign course   = item.angles_word[15:0];
  assign yaw      = item.angles_word[31:16];
  assign lat      = $signed(item.latitude_e7);
  assign lon      = $signed(item.longitude_e7);
  assign alt      = $signed(item.altitude_mm);

  assign tstat_ok  = (tstat == TS_LOCAL_FREE_RUN) || (tstat == TS_GPTP_SYNCED) ||
                     (tstat == TS_GPTP_HOLDOVER);
  assign time_ok   = !(flags[FLAG_TIME_BIT] && (item.unix_time_ns == 64'd0));
  assign course_ok = !(flags[FLAG_COURSE_BIT] && (course >= ANGLE_LIMIT));
  assign yaw_ok    = !(flags[FLAG_YAW_BIT] && (yaw >= ANGLE_LIMIT));

  assign chk.valid = (item.tail_padding == 48'd0) && (item.capture_time_ns != 64'd0) &&
                     (lat >= LAT_LOW) && (lat <= LAT_HIGH) &&
                     (lon >= LON_LOW) && (lon <= LON_HIGH) &&
                     ((flags & ~FLAG_ALLOWED) == 8'd0) &&
                     (fix_code <= FIX_MAX_CODE) && tstat_ok &&
                     time_ok && course_ok && yaw_ok;

  assign fix_ok = (fix_code >= FIX_3D) && (fix_code <= FIX_RTK_FIXED);
  assign alt_ok = (alt >= ALT_LOW) && (alt <= ALT_HIGH);
  assign acc_ok = (item.accuracy_word[15:0] <= lim.horiz) &&
                  (item.accuracy_word[31:16] <= lim.vert) &&
                  (item.accuracy_word[47:32] <= lim.speed);

  assign chk.usable = fix_ok && alt_ok && acc_ok;

endmodule

// ----- rtl/gnss_fix_validity_readiness_core.sv -----
// Checks GNSS fix samples and answers readiness queries, one result beat per input
// beat, in order. A beat is taken into an input register, checked and applied to the
// readiness state by one pass of logic, and its result lands in an output register;
// a new beat is taken every cycle while the result side keeps up. A sample that fails
// the structural checks, and any query, leaves the state alone. A usable fix needs a
// fix type code from 3D up to RTK fixed, altitude in range and all accuracies within
// their limits; fix_ready also needs enough usable samples in a row and a last sample
// no older than the recency window at the beat's now_ms.
`include "gnss_fix_validity_readiness_core_macros.svh"

module gnss_fix_validity_readiness_core
  import gfvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  // now_ms, new_session, capture_time_ns, latitude_e7, longitude_e7, altitude_mm,
  // status_word, unix_time_ns, angles_word, accuracy_word, tail_padding, zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // func
  input  logic                 in_tuser,

  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sample_valid, sample_usable, stable_run[2:0], fix_ready, zero pad
  output logic [7:0]           out_tdata,

  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_wdata
);

  logic [CNT_W-1:0] stable_needed_r;
  logic [LIM_W-1:0] recent_window_r;
  acc_lim_t         acc_lim_r;

  logic             in_valid_r;
  logic             in_func_r;
  item_t            in_item_r;

  logic             usable_r;
  logic [CNT_W-1:0] count_r;
  logic             sampled_r;
  logic [NOW_W-1:0] last_ms_r;

  logic             out_valid_r;
  logic [7:0]       out_data_r;

  logic             adv;
  chk_t             chk;
  logic             smp_ok;
  logic [CNT_W-1:0] count_base;
  logic [CNT_W-1:0] count_upd;
  logic             usable_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [NOW_W-1:0] age_ms;
  logic             recent;
  logic             ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_needed_r <= RST_STABLE_NEEDED;
      recent_window_r <= RST_RECENT_WINDOW;
      acc_lim_r.horiz <= RST_MAX_HORIZ_ACC;
      acc_lim_r.vert  <= RST_MAX_VERT_ACC;
      acc_lim_r.speed <= RST_MAX_SPEED_ACC;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_STABLE_NEEDED: stable_needed_r <= cfg_wdata[CNT_W-1:0];
        REG_RECENT_WINDOW: recent_window_r <= cfg_wdata;
        REG_MAX_HORIZ_ACC: acc_lim_r.horiz <= cfg_wdata;
        REG_MAX_VERT_ACC:  acc_lim_r.vert  <= cfg_wdata;
        REG_MAX_SPEED_ACC: acc_lim_r.speed <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser;
      in_item_r <= item_t'(in_tdata[ITEM_W-1:0]);
    end
  end

  gfvr_check u_check (
    .item (in_item_r),
    .lim  (acc_lim_r),
    .chk  (chk)
  );

  always_comb begin
    smp_ok     = (in_func_r == FUNC_SAMPLE) && chk.valid;
    count_base = (in_item_r.new_session || !chk.usable) ? '0 : count_r;
    count_upd  = count_base +
                 CNT_W'(chk.usable && (count_base < stable_needed_r));
    usable_nxt = smp_ok ? chk.usable : usable_r;
    count_nxt  = smp_ok ? count_upd : count_r;
    age_ms     = in_item_r.now_ms - last_ms_r;
    // a sample taken by this beat is zero ms old
    recent     = smp_ok || (sampled_r && (in_item_r.now_ms >= last_ms_r) &&
                 (age_ms <= NOW_W'(recent_window_r)));
    ready      = usable_nxt && (count_nxt >= stable_needed_r) && recent;
  end

  // readiness state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r  <= 1'b0;
      count_r   <= '0;
      sampled_r <= 1'b0;
    end else if (adv && smp_ok) begin
      usable_r  <= usable_nxt;
      count_r   <= count_nxt;
      sampled_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && smp_ok) begin
      last_ms_r <= in_item_r.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {2'b00, ready, count_nxt, usable_nxt, smp_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `GFVR_ASSERT(a_count_needs_usable, (count_r != '0) |-> usable_r, "stable count without usable fix")
  `GFVR_ASSERT(a_sampled_sticks, sampled_r |=> sampled_r, "sampled mark dropped")
  `GFVR_ASSERT(a_state_holds, !adv |=> ($stable(count_r) && $stable(usable_r)), "state moved without a beat")
  `GFVR_ASSERT(a_ready_needs_usable, (out_valid_r && out_data_r[5]) |-> out_data_r[1], "ready without usable fix")
  `GFVR_ASSERT_ALWAYS(a_empty_takes_beat, (rst_n && !in_valid_r) |-> in_tready, "empty input stage stalls")

endmodule
